// File: src/wpc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Windowed PID correction package
// Shared widths, register indexes and saturation limits for the correction
// core and its stream interfaces.
// ----------------------------------------------------------------------------
package wpc_pkg;

    // Field widths, all signed fixed point.
    localparam int ERR_W   = 16;   // error sample, Q4.12
    localparam int GAIN_W  = 16;   // gains, Q4.12
    localparam int CORR_W  = 32;   // correction, Q8.24
    localparam int DIFF_W  = ERR_W + 1;          // e - prev at full width
    localparam int AVG_W   = ERR_W + 1;          // window mean, magnitude may reach 32768
    localparam int PPROD_W = GAIN_W + ERR_W;     // kp * e
    localparam int DPROD_W = GAIN_W + DIFF_W;    // kd * (e - prev)
    localparam int IPROD_W = GAIN_W + AVG_W;     // ki * avg
    localparam int ACC_W   = DPROD_W + 2;        // sum of the three products

    // Saturation limits of the correction, at accumulator width.
    localparam logic signed [ACC_W-1:0] ACC_MAX = 35'sh0_7FFF_FFFF;
    localparam logic signed [ACC_W-1:0] ACC_MIN = 35'sh7_8000_0000;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_PROPORTIONAL = 2'd0,
        CFG_GAIN_INTEGRAL     = 2'd1,
        CFG_GAIN_DERIVATIVE   = 2'd2
    } cfg_reg_t;

endpackage : wpc_pkg
`default_nettype wire

// File: src/wpc_sample_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Error sample stream
// Valid/ready channel carrying one signed Q4.12 error sample per request.
// ----------------------------------------------------------------------------
interface wpc_sample_if
    import wpc_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic signed [ERR_W-1:0] error_sample;

    modport source (output valid, output error_sample, input ready);
    modport sink   (input valid, input error_sample, output ready);
endinterface : wpc_sample_if
`default_nettype wire

// File: src/wpc_result_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Correction result stream
// Valid/ready channel carrying one signed Q8.24 correction per request.
// ----------------------------------------------------------------------------
interface wpc_result_if
    import wpc_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic signed [CORR_W-1:0] correction;

    modport source (output valid, output correction, input ready);
    modport sink   (input valid, input correction, output ready);
endinterface : wpc_result_if
`default_nettype wire

// File: src/windowed_pid_correction_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Windowed PID correction core
// Turns each error sample into the negated, saturated PID sum, where the
// integral term is the truncated mean of the last WINDOW_DEPTH stored errors.
// ----------------------------------------------------------------------------
// Usage:
//   Error samples arrive on the samples channel and corrections leave on the
//   results channel; a request moves when valid and ready are both high.
//   Every sample yields exactly one correction, in order.
//   A correction moves through the stage registers in turn after the edge
//   that accepts its sample, and is valid once it holds the last stage.
//   Throughput is one sample per cycle unless the receiver stalls: the window
//   state (running sum, current error and the error shift line) is updated in
//   the accept cycle, and the four-stage datapath behind it is fully pipelined.
//   The three gains are written through cfg_write/cfg_index/cfg_data while
//   no request is in flight; a write to an unused index is ignored.
//   Reset clears the gains, the running sum, the current error, the error
//   window and all stage valid flags; the block is ready at once.
//   When the receiver stalls, each stage holds only while the stage after
//   it is occupied, so bubbles close up and samples keep being accepted until
//   all four stages are full.
// ----------------------------------------------------------------------------
module windowed_pid_correction_core
    import wpc_pkg::*;
#(
    parameter int WINDOW_DEPTH = 10
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    wpc_sample_if.sink                samples,
    wpc_result_if.source              results,
    input  wire logic                 cfg_write,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [GAIN_W-1:0]    cfg_data
);

    // Widths derived from the window depth. The magnitude of the running sum
    // never exceeds WINDOW_DEPTH * 2^15.
    localparam int DEPTH_LOG = $clog2(WINDOW_DEPTH);
    localparam int SUM_W     = ERR_W + 1 + DEPTH_LOG;
    localparam int MAG_W     = SUM_W - 1;
    localparam int MUL_W     = MAG_W + 2;
    localparam int SHIFT     = MAG_W + DEPTH_LOG;
    localparam int PROD_W    = MAG_W + MUL_W;
    localparam int QUOT_W    = AVG_W - 1;

    // Reciprocal of the depth, rounded up; exact for all magnitudes below
    // 2^MAG_W because 2^DEPTH_LOG is not less than the depth.
    localparam longint RECIP_L =
        ((64'sd1 <<< SHIFT) + WINDOW_DEPTH - 1) / WINDOW_DEPTH;
    localparam logic [MUL_W-1:0] RECIP = MUL_W'(RECIP_L);

    // Configuration registers.
    logic signed [GAIN_W-1:0] gain_p_reg;
    logic signed [GAIN_W-1:0] gain_i_reg;
    logic signed [GAIN_W-1:0] gain_d_reg;

    // Window state.
    logic signed [ERR_W-1:0]  cur_err_reg;
    logic signed [SUM_W-1:0]  sum_reg;
    logic signed [SUM_W-1:0]  sum_next;
    logic signed [ERR_W-1:0]  win_reg [WINDOW_DEPTH];
    logic signed [DIFF_W-1:0] diff_next;

    // Pipeline handshake.
    logic in_acc;
    logic adv1, adv2, adv3, adv4;
    logic v1_reg, v2_reg, v3_reg, v4_reg;

    // Stage 1: sample, difference and updated sum.
    logic signed [ERR_W-1:0]  s1_err_reg;
    logic signed [DIFF_W-1:0] s1_diff_reg;
    logic signed [SUM_W-1:0]  s1_sum_reg;

    // Stage 2: proportional and derivative products, mean magnitude.
    logic                      s1_neg;
    logic [MAG_W-1:0]          s1_mag;
    logic [PROD_W-1:0]         s1_recip_prod;
    logic signed [PPROD_W-1:0] p_prod_next;
    logic signed [DPROD_W-1:0] d_prod_next;
    logic signed [PPROD_W-1:0] s2_p_reg;
    logic signed [DPROD_W-1:0] s2_d_reg;
    logic [QUOT_W-1:0]         s2_quot_reg;
    logic                      s2_neg_reg;

    // Stage 3: integral product.
    logic signed [AVG_W-1:0]   s2_avg;
    logic signed [IPROD_W-1:0] i_prod_next;
    logic signed [PPROD_W-1:0] s3_p_reg;
    logic signed [DPROD_W-1:0] s3_d_reg;
    logic signed [IPROD_W-1:0] s3_i_reg;

    // Stage 4: negated, saturated sum.
    logic signed [ACC_W-1:0]   acc_sum;
    logic signed [ACC_W-1:0]   acc_neg;
    logic signed [CORR_W-1:0]  corr_next;
    logic signed [CORR_W-1:0]  corr_reg;

    // Gain register writes; unused indexes are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg <= '0;
            gain_i_reg <= '0;
            gain_d_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_GAIN_PROPORTIONAL: gain_p_reg <= cfg_data;
                CFG_GAIN_INTEGRAL:     gain_i_reg <= cfg_data;
                CFG_GAIN_DERIVATIVE:   gain_d_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // A stage advances when it is empty or the stage after it advances.
    assign adv4          = !v4_reg || results.ready;
    assign adv3          = !v3_reg || adv4;
    assign adv2          = !v2_reg || adv3;
    assign adv1          = !v1_reg || adv2;
    assign samples.ready = adv1;
    assign in_acc        = samples.valid && adv1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
                v1_reg <= samples.valid;
            if (adv2)
                v2_reg <= v1_reg;
            if (adv3)
                v3_reg <= v2_reg;
            if (adv4)
                v4_reg <= v3_reg;
        end
    end

    // The previous error enters the window and the oldest one leaves it.
    assign sum_next  = sum_reg + SUM_W'(cur_err_reg) - SUM_W'(win_reg[WINDOW_DEPTH-1]);
    assign diff_next = DIFF_W'(samples.error_sample) - DIFF_W'(cur_err_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_err_reg <= '0;
            sum_reg     <= '0;
            for (int i = 0; i < WINDOW_DEPTH; i++)
                win_reg[i] <= '0;
        end
        else if (in_acc)
        begin
            cur_err_reg <= samples.error_sample;
            sum_reg     <= sum_next;
            win_reg[0]  <= cur_err_reg;
            for (int i = 1; i < WINDOW_DEPTH; i++)
                win_reg[i] <= win_reg[i-1];
        end
    end

    // Stage 1 register.
    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            s1_err_reg  <= samples.error_sample;
            s1_diff_reg <= diff_next;
            s1_sum_reg  <= sum_next;
        end
    end

    // Mean magnitude by reciprocal multiplication, plus the two direct products.
    always_comb
    begin
        s1_neg        = s1_sum_reg[SUM_W-1];
        s1_mag        = s1_neg ? MAG_W'(-s1_sum_reg) : MAG_W'(s1_sum_reg);
        s1_recip_prod = PROD_W'(s1_mag) * PROD_W'(RECIP);
        p_prod_next   = gain_p_reg * s1_err_reg;
        d_prod_next   = gain_d_reg * s1_diff_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv2)
        begin
            s2_p_reg    <= p_prod_next;
            s2_d_reg    <= d_prod_next;
            s2_quot_reg <= s1_recip_prod[SHIFT +: QUOT_W];
            s2_neg_reg  <= s1_neg;
        end
    end

    // Restore the sign of the mean (truncation toward zero) and apply ki.
    always_comb
    begin
        s2_avg      = s2_neg_reg ? -$signed({1'b0, s2_quot_reg})
                                 :  $signed({1'b0, s2_quot_reg});
        i_prod_next = gain_i_reg * s2_avg;
    end

    always_ff @(posedge clk)
    begin
        if (adv3)
        begin
            s3_p_reg <= s2_p_reg;
            s3_d_reg <= s2_d_reg;
            s3_i_reg <= i_prod_next;
        end
    end

    // Sum, negate and clamp to the 32-bit range.
    always_comb
    begin
        acc_sum = ACC_W'(s3_p_reg) + ACC_W'(s3_d_reg) + ACC_W'(s3_i_reg);
        acc_neg = -acc_sum;
        if (acc_neg > ACC_MAX)
            corr_next = CORR_W'(ACC_MAX);
        else if (acc_neg < ACC_MIN)
            corr_next = CORR_W'(ACC_MIN);
        else
            corr_next = CORR_W'(acc_neg);
    end

    always_ff @(posedge clk)
    begin
        if (adv4)
            corr_reg <= corr_next;
    end

    assign results.valid      = v4_reg;
    assign results.correction = corr_reg;

`ifndef SYNTHESIS
    // The running sum moves only when a sample is accepted.
    a_sum_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !in_acc |=> $stable(sum_reg))
        else $error("window sum changed without an accepted sample");

    // The running sum tracks the entry and exit of the window.
    a_sum_track: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> sum_reg == $past(sum_reg) + SUM_W'($past(cur_err_reg))
                              - SUM_W'($past(win_reg[WINDOW_DEPTH-1])))
        else $error("window sum does not follow the error window");

    // An accepted sample becomes the current error and occupies stage one.
    a_cur_err: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> cur_err_reg == $past(samples.error_sample) && v1_reg)
        else $error("accepted sample not recorded");

    // A stalled result keeps its place in the output stage.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        v4_reg && !results.ready |=> v4_reg && $stable(corr_reg))
        else $error("stalled correction lost");
`endif

endmodule : windowed_pid_correction_core
`default_nettype wire

// File: sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Windowed PID correction core testbench
// Drives error samples into the core and checks each correction against a
// predictor. The predictor keeps its own error window, running sum and gains.
// The gains are changed between phases while the core is idle. Both stream
// sides idle at random, and once the result side holds off long enough to
// fill the core and stall its sample input.
// ----------------------------------------------------------------------------
module tb_top;
    import wpc_pkg::*;

    localparam int WINDOW_DEPTH   = 10;
    localparam int CLK_HIGH       = 6;
    localparam int CLK_LOW        = 6;
    localparam int RESET_CYCLES   = 8;
    localparam int DRAIN_CYCLES   = 8;
    localparam int LONG_HOLD      = 80;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_SAMPLES  = 179;
    localparam int MAX_REPORTS    = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

    localparam logic signed [ERR_W-1:0]  ERR_MAX  = 16'sh7FFF;
    localparam logic signed [ERR_W-1:0]  ERR_MIN  = 16'sh8000;
    localparam logic signed [GAIN_W-1:0] GAIN_MAX = 16'sh7FFF;
    localparam logic signed [GAIN_W-1:0] GAIN_MIN = 16'sh8000;

    // Predicts each correction from its own copy of the window state and
    // the gains, and holds the corrections still owed by the core.
    class corr_board_t;
        logic signed [ERR_W-1:0]  err_ring [WINDOW_DEPTH];
        int                       ring_slot;
        int                       ring_sum;
        logic signed [ERR_W-1:0]  last_err;
        logic signed [GAIN_W-1:0] kp;
        logic signed [GAIN_W-1:0] ki;
        logic signed [GAIN_W-1:0] kd;
        logic signed [CORR_W-1:0] owed_corrections [$];
        int                       failures;
        int                       checked;

        function new();
            foreach (err_ring[i])
                err_ring[i] = '0;
            ring_slot = 0;
            ring_sum  = 0;
            last_err  = '0;
            kp        = '0;
            ki        = '0;
            kd        = '0;
            failures  = 0;
            checked   = 0;
        endfunction

        function void set_gain(logic [CFG_IDX_W-1:0] idx, logic [GAIN_W-1:0] value);
            case (idx)
                CFG_GAIN_PROPORTIONAL: kp = value;
                CFG_GAIN_INTEGRAL:     ki = value;
                CFG_GAIN_DERIVATIVE:   kd = value;
                default: ;
            endcase
        endfunction

        // The previous error enters the ring before the new sample is used.
        function void note_sample(logic signed [ERR_W-1:0] e);
            longint prev;
            longint mean;
            longint acc;
            prev = longint'(last_err);
            ring_sum += int'(last_err) - int'(err_ring[ring_slot]);
            err_ring[ring_slot] = last_err;
            ring_slot = (ring_slot + 1) % WINDOW_DEPTH;
            last_err = e;
            // Signed division truncates toward zero.
            mean = longint'(ring_sum) / longint'(WINDOW_DEPTH);
            acc = -(longint'(kp) * longint'(e) + longint'(ki) * mean
                    + longint'(kd) * (longint'(e) - prev));
            if (acc > longint'(32'sh7FFF_FFFF))
                acc = longint'(32'sh7FFF_FFFF);
            if (acc < -longint'(64'sh8000_0000))
                acc = -longint'(64'sh8000_0000);
            owed_corrections = {owed_corrections, acc[CORR_W-1:0]};
        endfunction

        function void report(string what, logic signed [CORR_W-1:0] owed,
                             logic signed [CORR_W-1:0] got);
            failures++;
            if (failures <= MAX_REPORTS)
                $display("[%0t] %s: expected correction %0d, got %0d",
                         $time, what, owed, got);
        endfunction

        function void check_result(logic signed [CORR_W-1:0] got);
            logic signed [CORR_W-1:0] owed;
            checked++;
            if (owed_corrections.size() == 0)
                report("correction with no sample behind it", '0, got);
            else
            begin
                owed = owed_corrections.pop_front();
                if (got !== owed)
                    report("correction differs", owed, got);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic                 cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [GAIN_W-1:0]    cfg_data;

    wpc_sample_if samp ();
    wpc_result_if res ();

    corr_board_t board;

    bit no_idle;
    bit burst;
    bit hold_req;
    int gain_sets;
    int samples_sent;

    windowed_pid_correction_core #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .samples   (samp),
        .results   (res),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #CLK_LOW  clk = 1'b1;
        #CLK_HIGH clk = 1'b0;
    end

    // Mostly no gap, some short ones and a few long ones.
    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Offer one sample and wait until the core takes the request.
    task automatic send_sample(input logic signed [ERR_W-1:0] e);
        int gap;
        gap = burst ? 0 : pick_gap();
        if (gap > 0)
        begin
            samp.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        samp.valid        <= 1'b1;
        samp.error_sample <= e;
        @(posedge clk);
        while (samp.ready !== 1'b1)
            @(posedge clk);
        board.note_sample(e);
        samples_sent++;
    endtask

    // Stop offering and wait until every owed correction has come back.
    task automatic drain();
        samp.valid <= 1'b0;
        while (board.owed_corrections.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write all three gains back to back, optionally also the unused index.
    task automatic program_gains(input logic [GAIN_W-1:0] kp, input logic [GAIN_W-1:0] ki,
                                 input logic [GAIN_W-1:0] kd, input bit poke_unused);
        logic [GAIN_W-1:0] junk;
        cfg_write <= 1'b1;
        cfg_index <= CFG_GAIN_PROPORTIONAL;
        cfg_data  <= kp;
        @(posedge clk);
        board.set_gain(CFG_GAIN_PROPORTIONAL, kp);
        cfg_index <= CFG_GAIN_INTEGRAL;
        cfg_data  <= ki;
        @(posedge clk);
        board.set_gain(CFG_GAIN_INTEGRAL, ki);
        cfg_index <= CFG_GAIN_DERIVATIVE;
        cfg_data  <= kd;
        @(posedge clk);
        board.set_gain(CFG_GAIN_DERIVATIVE, kd);
        if (poke_unused)
        begin
            junk = GAIN_W'($urandom());
            cfg_index <= CFG_UNUSED_IDX;
            cfg_data  <= junk;
            @(posedge clk);
            board.set_gain(CFG_UNUSED_IDX, junk);
        end
        cfg_write <= 1'b0;
        gain_sets++;
    endtask

    function automatic logic [GAIN_W-1:0] draw_gain(int style);
        int r;
        case (style)
            0: return GAIN_W'($urandom());
            1: return GAIN_W'($urandom_range(0, 8192) - 4096);
            default:
            begin
                r = $urandom_range(0, 2);
                if (r == 0)
                    return GAIN_MIN;
                if (r == 1)
                    return GAIN_MAX;
                return '0;
            end
        endcase
    endfunction

    // Result side: random ready with gaps, plus one long hold on request.
    initial
    begin
        int hold_left;
        int ready_left;
        hold_left  = 0;
        ready_left = 0;
        res.ready  = 1'b0;
        @(posedge clk);
        while (rst_n !== 1'b1)
            @(posedge clk);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res.ready <= 1'b0;
            end
            else if (ready_left > 0)
            begin
                ready_left--;
                res.ready <= 1'b1;
            end
            else
            begin
                hold_left  = pick_gap();
                ready_left = $urandom_range(1, 12);
                if (hold_left > 0)
                begin
                    hold_left--;
                    res.ready <= 1'b0;
                end
                else
                begin
                    ready_left--;
                    res.ready <= 1'b1;
                end
            end
        end
    end

    // Check every correction the core hands over.
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && res.valid === 1'b1 && res.ready === 1'b1)
            board.check_result(res.correction);
    end

    // Watchdog: too long with no request moving on either side.
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((samp.valid === 1'b1 && samp.ready === 1'b1)
                || (res.valid === 1'b1 && res.ready === 1'b1))
                quiet = 0;
            else
                quiet++;
        end
        $display("Timed out after %0d cycles with no request moving", WATCHDOG_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Main sequence.
    initial
    begin
        int style;
        int gain_style;
        logic signed [ERR_W-1:0] e;
        logic signed [ERR_W-1:0] run_value;

        board             = new();
        rst_n             = 1'b0;
        cfg_write         = 1'b0;
        cfg_index         = '0;
        cfg_data          = '0;
        samp.valid        = 1'b0;
        samp.error_sample = '0;
        no_idle           = 1'b0;
        burst             = 1'b0;
        hold_req          = 1'b0;
        gain_sets         = 0;
        samples_sent      = 0;
        style             = 0;
        run_value         = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // With the reset gains every correction must be zero.
        send_sample(ERR_MAX);
        send_sample(ERR_MIN);
        drain();

        // Most negative gains: large swings drive the correction to both limits.
        program_gains(GAIN_MIN, GAIN_MIN, GAIN_MIN, 1'b0);
        send_sample(ERR_MIN);
        send_sample(ERR_MAX);
        send_sample(ERR_MIN);
        send_sample('0);
        send_sample(-16'sd1);
        send_sample(16'sd1);
        drain();

        // Most positive gains, unused index written too: fill the window with
        // the most negative error, then swing to the most positive one.
        program_gains(GAIN_MAX, GAIN_MAX, GAIN_MAX, 1'b1);
        repeat (WINDOW_DEPTH + 1) send_sample(ERR_MIN);
        send_sample(ERR_MAX);
        drain();

        // Random phases, each with its own gain setting.
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            gain_style = $urandom_range(0, 3);
            if (gain_style == 3)
                program_gains(draw_gain(0), '0, draw_gain(1), 1'($urandom_range(0, 1)));
            else
                program_gains(draw_gain(gain_style), draw_gain(gain_style),
                              draw_gain(gain_style), 1'($urandom_range(0, 1)));
            for (int n = 0; n < PHASE_SAMPLES; n++)
            begin
                // A new sample pattern and idling mode every sixteen samples.
                if (n % 16 == 0)
                begin
                    style     = $urandom_range(0, 4);
                    run_value = ERR_W'($urandom());
                    no_idle   = ($urandom_range(0, 3) == 0);
                end
                // One long hold on the result side while samples keep coming.
                if (phase == 2 && n == 40)
                begin
                    burst    = 1'b1;
                    hold_req = 1'b1;
                end
                if (phase == 2 && n == 80)
                    burst = 1'b0;
                case (style)
                    0, 1: e = ERR_W'($urandom());
                    2: e = ERR_W'($urandom_range(0, 512) - 256);
                    3:
                    begin
                        case ($urandom_range(0, 3))
                            0: e = ERR_MAX;
                            1: e = ERR_MIN;
                            2: e = '0;
                            default: e = -16'sd1;
                        endcase
                    end
                    default: e = run_value;
                endcase
                send_sample(e);
            end
            drain();
        end
        no_idle = 1'b0;

        $display("Sent %0d error samples under %0d gain settings; %0d corrections checked.",
                 samples_sent, gain_sets, board.checked);
        $display("Included saturation at both ends, full windows and one long output hold.");
        if (board.failures == 0)
            $display("SCOREBOARD CLEAN");
        else
        begin
            $display("%0d corrections failed", board.failures);
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// File: files.f
src/wpc_pkg.sv
src/wpc_sample_if.sv
src/wpc_result_if.sv
src/windowed_pid_correction_core.sv
sim/tb_top.sv
